### rtl/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg
// Shared field widths, opcodes, status codes and register indexes of the
// double-ended region stack.
// ----------------------------------------------------------------------------
package des_pkg;

   localparam int OPCODE_W    = 2;
   localparam int SLOT_FIELD_W = 4;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;

   typedef logic [OPCODE_W-1:0]    opcode_type;
   typedef logic [STATUS_W-1:0]    status_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam opcode_type OP_PUSH_UP   = 2'd0;
   localparam opcode_type OP_PUSH_DOWN = 2'd1;
   localparam opcode_type OP_RESIZE    = 2'd2;
   localparam opcode_type OP_INIT      = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_NO_SLOT = 2'd1;
   localparam status_type ST_NOT_TOP = 2'd2;

   localparam csr_index_type CSR_LOW_BASE   = 2'd0;
   localparam csr_index_type CSR_HIGH_LIMIT = 2'd1;

endpackage

### rtl/des_req_if.sv
// ----------------------------------------------------------------------------
// des_req_if
// Request channel: one operation item with opcode, slot and size.
// ----------------------------------------------------------------------------
interface des_req_if import des_pkg::*; ();

   logic                    valid;
   logic                    ready;
   opcode_type              opcode;
   logic [SLOT_FIELD_W-1:0] slot_index;
   logic [DATA_W-1:0]       new_size;

   modport source (output valid, output opcode, output slot_index, output new_size,
                   input ready);
   modport sink   (input valid, input opcode, input slot_index, input new_size,
                   output ready);

endinterface

### rtl/des_rsp_if.sv
// ----------------------------------------------------------------------------
// des_rsp_if
// Response channel: status, slot and bounds of the region an item touched.
// ----------------------------------------------------------------------------
interface des_rsp_if import des_pkg::*; ();

   logic                    valid;
   logic                    ready;
   status_type              status;
   logic [SLOT_FIELD_W-1:0] result_slot;
   logic [DATA_W-1:0]       start_address;
   logic [DATA_W-1:0]       end_address;

   modport source (output valid, output status, output result_slot,
                   output start_address, output end_address, input ready);
   modport sink   (input valid, input status, input result_slot,
                   input start_address, input end_address, output ready);

endinterface

### rtl/des_csr_if.sv
// ----------------------------------------------------------------------------
// des_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface des_csr_if import des_pkg::*; ();

   logic              valid;
   logic              ready;
   csr_index_type     index;
   logic [DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);

endinterface

### rtl/des_ram.sv
// ----------------------------------------------------------------------------
// des_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module des_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/double_ended_region_stack.sv
// ----------------------------------------------------------------------------
// double_ended_region_stack
// Arena manager keeping two stacks of regions in a slot table: one grows up
// from the low base, the other grows down from the high limit.
// ----------------------------------------------------------------------------
// An item is accepted in idle, when the slot table is read; the execute state
// writes the table back and registers the result, and init also writes the
// downward stack bottom in a further state. Items are taken only in idle. A
// stalled result register holds the block in its execute state.
// Reset clears both tops to their stack bottoms and both base registers to
// zero; the slot table is not cleared and holds nothing valid until init.
module double_ended_region_stack import des_pkg::*; #(
   parameter int MAX_REGIONS = 14,
   parameter int ADDR_WIDTH  = 32
) (
   input logic      clock,
   input logic      reset,
   des_req_if.sink  req_ch,
   des_rsp_if.source rsp_ch,
   des_csr_if.sink  csr_ch
);

   localparam int SLOT_COUNT = MAX_REGIONS + 2;
   localparam int SW = $clog2(SLOT_COUNT);
   localparam int CW = (SW > SLOT_FIELD_W) ? SW : SLOT_FIELD_W;
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_EXEC    = 2'd1;
   localparam logic [1:0] S_INIT_HI = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [SW-1:0]         low_top_ff, low_top_in;
   logic [SW-1:0]         high_top_ff, high_top_in;
   logic [DATA_W-1:0]     low_base_ff, high_limit_ff;

   opcode_type            op_ff;
   logic [SLOT_FIELD_W-1:0] idx_ff;
   logic [DATA_W-1:0]     size_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, status_c;
   logic [SLOT_FIELD_W-1:0] rsp_slot_ff, slot_c;
   logic [DATA_W-1:0]     rsp_start_ff, rsp_end_ff;
   logic [ADDR_WIDTH-1:0] start_c, end_c;

   logic                  out_free, exec_fire;
   opcode_type            rd_op;
   logic [CW-1:0]         rd_idx_ext, idx_ext;
   logic [SW-1:0]         rd_addr, wr_addr;
   logic                  st_we, en_we;
   logic [ADDR_WIDTH-1:0] st_wd, en_wd, rd_start, rd_end;
   logic                  stacks_full, idx_beyond, at_low_top, at_high_top;
   logic [ADDR_WIDTH-1:0] grown_end, grown_start;
   logic [CW-1:0]         low_top_ext, high_top_ext;

   // ---------------------------------------------------------------- handshakes
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign exec_fire    = (state_ff == S_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_base_ff   <= '0;
         high_limit_ff <= '0;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_LOW_BASE) begin
            low_base_ff <= csr_ch.data;
         end else if (csr_ch.index == CSR_HIGH_LIMIT) begin
            high_limit_ff <= csr_ch.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         op_ff   <= req_ch.opcode;
         idx_ff  <= req_ch.slot_index;
         size_ff <= req_ch.new_size;
      end
   end

   // ---------------------------------------------------------------- slot table
   // The read address comes straight from the request in the accept cycle and
   // from the latched item afterwards, so the read data holds during a stall.
   assign rd_op      = (state_ff == S_IDLE) ? req_ch.opcode : op_ff;
   assign rd_idx_ext = CW'((state_ff == S_IDLE) ? req_ch.slot_index : idx_ff);

   always_comb begin
      unique case (rd_op)
         OP_PUSH_UP:   rd_addr = low_top_ff;
         OP_PUSH_DOWN: rd_addr = high_top_ff;
         OP_RESIZE:    rd_addr = rd_idx_ext[SW-1:0];
         default:      rd_addr = '0;
      endcase
   end

   des_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(SLOT_COUNT)) u_start_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (wr_addr),
      .wr_data (st_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_start)
   );

   des_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(SLOT_COUNT)) u_end_ram (
      .clock   (clock),
      .wr_en   (en_we),
      .wr_addr (wr_addr),
      .wr_data (en_wd),
      .rd_addr (rd_addr),
      .rd_data (rd_end)
   );

   // ---------------------------------------------------------------- execute
   assign idx_ext      = CW'(idx_ff);
   assign low_top_ext  = CW'(low_top_ff);
   assign high_top_ext = CW'(high_top_ff);
   assign stacks_full  = ({1'b0, high_top_ff} <= ({1'b0, low_top_ff} + (SW+1)'(1)));
   assign idx_beyond   = ({1'b0, idx_ext} >= (CW+1)'(SLOT_COUNT));
   assign at_low_top   = (idx_ext == low_top_ext) && (low_top_ff != '0);
   assign at_high_top  = (idx_ext == high_top_ext) && (high_top_ff != LAST_SLOT);
   assign grown_end    = rd_start + ADDR_WIDTH'(size_ff);
   assign grown_start  = rd_end - ADDR_WIDTH'(size_ff);

   always_comb begin
      state_in    = state_ff;
      low_top_in  = low_top_ff;
      high_top_in = high_top_ff;
      st_we       = 1'b0;
      en_we       = 1'b0;
      wr_addr     = '0;
      st_wd       = rd_start;
      en_wd       = rd_end;
      status_c    = ST_OK;
      slot_c      = '0;
      start_c     = '0;
      end_c       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_INIT: begin
                  st_wd   = ADDR_WIDTH'(low_base_ff);
                  en_wd   = ADDR_WIDTH'(low_base_ff);
                  st_we   = exec_fire;
                  en_we   = exec_fire;
                  start_c = ADDR_WIDTH'(low_base_ff);
                  end_c   = ADDR_WIDTH'(low_base_ff);
               end
               OP_PUSH_UP: begin
                  if (stacks_full) begin
                     status_c = ST_NO_SLOT;
                  end else begin
                     wr_addr = low_top_ff + SW'(1);
                     st_wd   = rd_end;
                     en_wd   = rd_end;
                     st_we   = exec_fire;
                     en_we   = exec_fire;
                     slot_c  = SLOT_FIELD_W'(CW'(wr_addr));
                     start_c = rd_end;
                     end_c   = rd_end;
                  end
               end
               OP_PUSH_DOWN: begin
                  if (stacks_full) begin
                     status_c = ST_NO_SLOT;
                  end else begin
                     wr_addr = high_top_ff - SW'(1);
                     st_wd   = rd_start;
                     en_wd   = rd_start;
                     st_we   = exec_fire;
                     en_we   = exec_fire;
                     slot_c  = SLOT_FIELD_W'(CW'(wr_addr));
                     start_c = rd_start;
                     end_c   = rd_start;
                  end
               end
               default: begin
                  wr_addr = idx_ext[SW-1:0];
                  slot_c  = idx_ff;
                  if (idx_beyond) begin
                     status_c = ST_NOT_TOP;
                  end else if (at_low_top) begin
                     en_wd   = grown_end;
                     en_we   = exec_fire;
                     start_c = rd_start;
                     end_c   = grown_end;
                  end else if (at_high_top) begin
                     st_wd   = grown_start;
                     st_we   = exec_fire;
                     start_c = grown_start;
                     end_c   = rd_end;
                  end else begin
                     status_c = ST_NOT_TOP;
                     start_c  = rd_start;
                     end_c    = rd_end;
                  end
               end
            endcase

            if (exec_fire) begin
               state_in = S_IDLE;
               if (op_ff == OP_INIT) begin
                  state_in    = S_INIT_HI;
                  low_top_in  = '0;
                  high_top_in = LAST_SLOT;
               end else if (op_ff == OP_PUSH_UP && !stacks_full) begin
                  low_top_in = low_top_ff + SW'(1);
               end else if (op_ff == OP_PUSH_DOWN && !stacks_full) begin
                  high_top_in = high_top_ff - SW'(1);
               end
            end
         end
         S_INIT_HI: begin
            // Second write of init: the bottom of the downward stack.
            wr_addr  = LAST_SLOT;
            st_wd    = ADDR_WIDTH'(high_limit_ff);
            en_wd    = ADDR_WIDTH'(high_limit_ff);
            st_we    = 1'b1;
            en_we    = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         low_top_ff   <= '0;
         high_top_ff  <= LAST_SLOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_top_ff   <= low_top_in;
         high_top_ff  <= high_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_status_ff <= status_c;
         rsp_slot_ff   <= slot_c;
         rsp_start_ff  <= DATA_W'(start_c);
         rsp_end_ff    <= DATA_W'(end_c);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.result_slot   = rsp_slot_ff;
   assign rsp_ch.start_address = rsp_start_ff;
   assign rsp_ch.end_address   = rsp_end_ff;

   // ---------------------------------------------------------------- checks
   // The upward top always stays strictly below the downward top.
   a_tops_ordered: assert property (@(posedge clock) disable iff (reset)
      low_top_ff < high_top_ff)
      else $error("stack tops crossed");

   // The slot table is never written while the block waits for an item.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !st_we && !en_we)
      else $error("slot table written while idle");

   // A finished execute cycle always leaves a result in the output register.
   a_exec_result: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("execute finished without a result");

   // A successful upward push raises the upward top by exactly one.
   a_push_up_top: assert property (@(posedge clock) disable iff (reset)
      exec_fire && op_ff == OP_PUSH_UP && !stacks_full
      |=> low_top_ff == $past(low_top_ff) + SW'(1))
      else $error("upward push did not advance the top");

endmodule
